// ===== rtl/core/sha1_message_digest_assert.svh =====
// Assertion macros shared by the digest checker.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA1_ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA1_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/sha1_pkg.sv =====
// Shared types and constants of the SHA-1 digest block.
package sha1_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       final_item;
	} sha1_in_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} sha1_out_t;

	localparam int SHA1_QUEUE_DEPTH = 4;

	localparam logic [31:0] SHA1_K0 = 32'h5A827999;
	localparam logic [31:0] SHA1_K1 = 32'h6ED9EBA1;
	localparam logic [31:0] SHA1_K2 = 32'h8F1BBCDC;
	localparam logic [31:0] SHA1_K3 = 32'hCA62C1D6;
	localparam logic [159:0] SHA1_INIT =
		160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
	localparam logic [7:0] SHA1_PAD_MARK = 8'b10000000;

	// Beat from the front part to the back part: one byte to pack.
	typedef struct packed {
		logic [7:0] data;
		logic       last;   // final byte of the padded message
	} sha1_cmd_t;

	function automatic logic [31:0] sha1_rotl(input logic [31:0] x, input int unsigned n);
		sha1_rotl = (x << n) | (x >> (32 - n));
	endfunction
endpackage

// ===== rtl/core/sha1_message_digest.sv =====
// SHA-1 digest: at most one message byte per accepted item, 80 rounds per 512-bit block.
// A byte item keeps full high until the queue takes its byte; the back part packs one byte
// per cycle while filling and the queue is not empty, then runs 80 rounds and one chain update.
// A final item adds 9 to 72 padding bytes; the first digest word is ready after the last
// block's rounds and chain update, and each of the five words holds until popped.
// Reset (arst_n low) returns the chaining value, byte count and queue to start.
module sha1_message_digest
	import sha1_pkg::*;
#(
	parameter int QUEUE_DEPTH = SHA1_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sha1_in_t  in_data,
	input  logic      push,
	output logic      full,
	output sha1_out_t out_data,
	output logic      empty,
	input  logic      pop
);
	sha1_cmd_t cmd_w, cmd_r;
	logic      cmd_valid, q_full, q_empty, q_pop;

	sha1_front u_front (
		.clk(clk), .arst_n(arst_n), .in_data(in_data), .push(push), .full(full),
		.cmd(cmd_w), .cmd_valid(cmd_valid), .cmd_full(q_full)
	);

	sha1_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_data(cmd_w), .wr_en(cmd_valid), .full(q_full),
		.rd_data(cmd_r), .empty(q_empty), .rd_en(q_pop)
	);

	sha1_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_r), .cmd_empty(q_empty), .cmd_pop(q_pop),
		.out_data(out_data), .empty(empty), .pop(pop)
	);
endmodule

// ===== rtl/core/sha1_front.sv =====
// Front part: counts message bytes and expands a final item into padding bytes.
module sha1_front
	import sha1_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sha1_in_t  in_data,
	input  logic      push,
	output logic      full,
	output sha1_cmd_t cmd,
	output logic      cmd_valid,
	input  logic      cmd_full
);
	typedef enum logic [1:0] {ST_IDLE, ST_BYTE, ST_PAD} state_t;

	state_t      state_q;
	logic [7:0]  byte_q;
	logic        final_q;
	logic [60:0] count_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic        mark_q;
	logic        pad_len_q;   // length bytes go into the current block

	assign full = (state_q != ST_IDLE);

	// Select the byte offered to the queue in each state.
	always_comb begin
		cmd = '0;
		cmd_valid = 1'b0;
		case (state_q)
			ST_BYTE: begin
				cmd.data = byte_q;
				cmd_valid = 1'b1;
			end
			ST_PAD: begin
				cmd_valid = 1'b1;
				if (mark_q)
					cmd.data = SHA1_PAD_MARK;
				else if (pad_len_q && fill_q >= 6'd56)
					cmd.data = bits_q[63:56];
				else
					cmd.data = 8'h00;
				cmd.last = !mark_q && pad_len_q && (fill_q == 6'd63);
			end
			default: ;
		endcase
	end

	// Advance the byte stream one beat per free queue slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			fill_q <= '0;
			final_q <= 1'b0;
			mark_q <= 1'b0;
			pad_len_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (push) begin
						byte_q <= in_data.data_byte;
						final_q <= in_data.final_item;
						if (in_data.byte_present)
							state_q <= ST_BYTE;
						else if (in_data.final_item) begin
							state_q <= ST_PAD;
							mark_q <= 1'b1;
							bits_q <= {count_q, 3'b000};
						end
					end
				end
				ST_BYTE: begin
					if (!cmd_full) begin
						fill_q <= fill_q + 6'd1;
						if (final_q) begin
							state_q <= ST_PAD;
							mark_q <= 1'b1;
							bits_q <= {count_q + 61'd1, 3'b000};
							count_q <= count_q + 61'd1;
						end else begin
							state_q <= ST_IDLE;
							count_q <= count_q + 61'd1;
						end
					end
				end
				ST_PAD: begin
					if (!cmd_full) begin
						fill_q <= fill_q + 6'd1;
						mark_q <= 1'b0;
						// a mark past byte 55 pushes the length into the next block
						if (fill_q == 6'd63)
							pad_len_q <= 1'b1;
						else if (mark_q)
							pad_len_q <= (fill_q < 6'd56);
						if (!mark_q && pad_len_q && fill_q >= 6'd56)
							bits_q <= {bits_q[55:0], 8'h00};
						if (!mark_q && pad_len_q && fill_q == 6'd63) begin
							state_q <= ST_IDLE;
							count_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/sha1_queue.sv =====
// Short queue of byte beats between the front and back parts.
module sha1_queue
	import sha1_pkg::*;
#(
	parameter int DEPTH = SHA1_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sha1_cmd_t wr_data,
	input  logic      wr_en,
	output logic      full,
	output sha1_cmd_t rd_data,
	output logic      empty,
	input  logic      rd_en
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sha1_cmd_t     mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rp_q];

	// Write, read and count beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !full) begin
				mem_q[wp_q] <= wr_data;
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			end
			if (rd_en && !empty)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
		end
	end
endmodule

// ===== rtl/core/sha1_back.sv =====
// Back part: packs bytes, runs 80 rounds per block and emits the digest.
module sha1_back
	import sha1_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sha1_cmd_t cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	output sha1_out_t out_data,
	output logic      empty,
	input  logic      pop
);
	typedef enum logic [1:0] {ST_FILL, ST_ROUND, ST_SUM, ST_OUT} state_t;

	state_t       state_q;
	logic [31:0]  w_q [16];
	logic [5:0]   fill_q;
	logic [6:0]   round_q;
	logic [159:0] h_q;
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic         last_q;
	logic [2:0]   word_q;
	logic [31:0]  f, k, tmp, wnew;

	assign cmd_pop = (state_q == ST_FILL) && !cmd_empty;
	assign empty = (state_q != ST_OUT);
	assign out_data.digest_word = h_q[159:128];
	assign out_data.last_word = (word_q == 3'd4);

	// Round function and schedule word for the current round.
	always_comb begin
		if (round_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = SHA1_K0;
		end else if (round_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = SHA1_K1;
		end else if (round_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = SHA1_K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = SHA1_K3;
		end
		wnew = sha1_rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		tmp = sha1_rotl(a_q, 5) + f + e_q + w_q[0] + k;
	end

	// Sequence fill, rounds, chain update and word output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q <= '0;
			round_q <= '0;
			h_q <= SHA1_INIT;
			last_q <= 1'b0;
			word_q <= '0;
		end else begin
			case (state_q)
				ST_FILL: begin
					if (!cmd_empty) begin
						w_q[fill_q[5:2]] <= {w_q[fill_q[5:2]][23:0], cmd.data};
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							last_q <= cmd.last;
							round_q <= '0;
							{a_q, b_q, c_q, d_q, e_q} <= h_q;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++)
						w_q[i] <= w_q[i+1];
					w_q[15] <= wnew;
					e_q <= d_q;
					d_q <= c_q;
					c_q <= sha1_rotl(b_q, 30);
					b_q <= a_q;
					a_q <= tmp;
					round_q <= round_q + 7'd1;
					if (round_q == 7'd79)
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					h_q <= {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
						h_q[63:32] + d_q, h_q[31:0] + e_q};
					round_q <= '0;
					word_q <= '0;
					state_q <= last_q ? ST_OUT : ST_FILL;
				end
				ST_OUT: begin
					if (pop) begin
						word_q <= word_q + 3'd1;
						if (word_q == 3'd4) begin
							h_q <= SHA1_INIT;
							state_q <= ST_FILL;
						end else begin
							h_q <= {h_q[127:0], 32'h0};
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end
endmodule

// ===== rtl/core/sha1_checker.sv =====
// Port checker for the SHA-1 digest block and its bind.
`include "sha1_message_digest_assert.svh"
module sha1_checker
	import sha1_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input sha1_in_t  in_data,
	input logic      push,
	input logic      full,
	input sha1_out_t out_data,
	input logic      empty,
	input logic      pop
);
	`SHA1_ASSERT_NEXT(a_word_holds, clk, arst_n, !empty && !pop, !empty && $stable(out_data))
	`SHA1_ASSERT_NEXT(a_last_ends, clk, arst_n, !empty && pop && out_data.last_word, empty)
	`SHA1_ASSERT_IMPL(a_out_known, clk, arst_n, !empty, !$isunknown(out_data))
	`SHA1_ASSERT_NEXT(a_push_blocks, clk, arst_n, push && !full && (in_data.byte_present || in_data.final_item), full)
endmodule

bind sha1_message_digest sha1_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_data(in_data), .push(push), .full(full),
	.out_data(out_data), .empty(empty), .pop(pop)
);
